// ===== rtl/core/window_convolution_3x3_normalized_macros.svh =====
// Assertion macros for the 3x3 normalized convolution block.
// Used by the port checker; no other dependencies.
`ifndef WINDOW_CONVOLUTION_3X3_NORMALIZED_MACROS_SVH
`define WINDOW_CONVOLUTION_3X3_NORMALIZED_MACROS_SVH

// clocked assertion, masked while reset is asserted
`define WCN_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("wcn assertion failed");

// clocked assertion that also holds during reset
`define WCN_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("wcn assertion failed");

`endif

// ===== rtl/core/wcn_pkg.sv =====
// Shared types, constants and helpers for the 3x3 normalized convolution.
// No dependencies.
`default_nettype none
package wcn_pkg;
    localparam int PIX_MAX   = 255;
    localparam int COL_LIMIT = 1024;

    localparam logic [2:0] CFG_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_KTOP   = 3'd2;
    localparam logic [2:0] CFG_KMID   = 3'd3;
    localparam logic [2:0] CFG_KBOT   = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MAC,
        S_DSTART,
        S_DIV,
        S_OUT_I,
        S_OUT_B
    } t_state;

    function automatic logic signed [7:0] coef(input logic [23:0] krow, input logic [1:0] j);
        logic signed [7:0] c;
        case (j)
            2'd0:    c = krow[7:0];
            2'd1:    c = krow[15:8];
            default: c = krow[23:16];
        endcase
        return c;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/wcn_line_mem.sv =====
// Line store: rows r-2 and r-1 packed in one word per column.
// Synchronous memory, one read and one write port, registered read.
`default_nettype none
module wcn_line_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [15:0]   o_rd_data,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [15:0]   i_wr_data
);
    logic [15:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/wcn_div.sv =====
// Signed restoring divider, one quotient bit per cycle, truncates toward zero.
// No dependencies.
`default_nettype none
module wcn_div (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic signed [19:0]  i_dividend,
    input  wire logic signed [11:0]  i_divisor,
    output logic                     o_done,
    output logic signed [19:0]       o_quotient
);
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_cnt, n_cnt;
    logic [11:0] r_rem, n_rem;
    logic [18:0] r_quo, n_quo;
    logic [10:0] r_dvs, n_dvs;
    logic        r_neg, n_neg;

    logic [19:0] abs_dd;
    logic [11:0] abs_ds;
    logic [11:0] rem_sh;

    always_comb begin
        abs_dd = i_dividend[19] ? 20'(-i_dividend) : i_dividend;
        abs_ds = i_divisor[11] ? 12'(-i_divisor) : i_divisor;
        rem_sh = {r_rem[10:0], r_quo[18]};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        n_neg  = r_neg;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 5'd0;
            n_rem  = 12'd0;
            n_quo  = abs_dd[18:0];
            n_dvs  = (abs_ds == 12'd0) ? 11'd1 : abs_ds[10:0];
            n_neg  = i_dividend[19] ^ i_divisor[11];
        end else if (r_busy) begin
            if (rem_sh >= {1'b0, r_dvs}) begin
                n_rem = rem_sh - {1'b0, r_dvs};
                n_quo = {r_quo[17:0], 1'b1};
            end else begin
                n_rem = rem_sh;
                n_quo = {r_quo[17:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd18) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
        r_neg <= n_neg;
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
endmodule
`default_nettype wire

// ===== rtl/core/window_convolution_3x3_normalized.sv =====
// Top level of the 3x3 normalized convolution over a raster pixel stream.
// Uses wcn_pkg, wcn_line_mem and wcn_div.
//
// channel   dir  tdata                               tlast        tuser
// s_axis    in   [7:0] pixel                         -            -
// m_axis    out  [19:0] value [31:20] row [41:32] col last_of_run last_of_frame
// cfg       in   i_cfg_idx selects register, i_cfg_data is written when i_cfg_we
//
// One item at a time. A border-only item is read, then its result is offered.
// An interior item is read, passed through a shared multiply-accumulate, the divider start
// state and the bit-serial divider, then its results are offered. Results hold while m_axis_tready is low.
// Synchronous active-low reset; line store has no clearing pass.
`default_nettype none
module window_convolution_3x3_normalized #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] pixel
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // [19:0] value, [31:20] row, [41:32] col
    output logic             m_axis_tlast,   // last_of_run
    output logic             m_axis_tuser,   // last_of_frame
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [23:0] i_cfg_data
);
    import wcn_pkg::*;

    localparam int LDEPTH = (MAX_WIDTH < COL_LIMIT) ? MAX_WIDTH : COL_LIMIT;
    localparam int AW     = $clog2(LDEPTH);

    t_state r_state, n_state;

    logic [10:0] r_width;
    logic [11:0] r_height;
    logic [23:0] r_krow [3];

    logic [11:0] r_row, n_row;
    logic [9:0]  r_col, n_col;
    logic [7:0]  r_win [9];
    logic [7:0]  r_pix;
    logic [3:0]  r_k;
    logic signed [19:0] r_acc;
    logic signed [11:0] r_ksum;
    logic [11:0] r_irow, r_brow;
    logic [9:0]  r_icol, r_bcol;
    logic        r_bord, r_fend;

    logic        in_hs, out_hs;
    logic [15:0] rd_data;
    logic        wr_en;
    logic [10:0] w_eff;
    logic        row_end, last_row, frame_end, border, interior;
    logic [1:0]  k_row, k_col;
    logic signed [16:0] prod;
    logic signed [7:0]  kc;
    logic signed [19:0] quot, ival;
    logic        div_start, div_done;

    assign in_hs  = s_axis_tvalid & s_axis_tready;
    assign out_hs = m_axis_tvalid & m_axis_tready;

    always_comb begin
        w_eff     = (r_width > 11'(LDEPTH)) ? 11'(LDEPTH) : r_width;
        row_end   = ({1'b0, r_col} + 11'd1) >= w_eff;
        last_row  = ({1'b0, r_row} + 13'd1) >= {1'b0, r_height};
        frame_end = row_end & last_row;
        border    = (r_row == 12'd0) | (r_col == 10'd0) | row_end | last_row;
        interior  = (r_row >= 12'd2) & (r_col >= 10'd2);
        n_col     = row_end ? 10'd0 : r_col + 10'd1;
        n_row     = row_end ? (frame_end ? 12'd0 : r_row + 12'd1) : r_row;
        k_row     = (r_k >= 4'd6) ? 2'd2 : ((r_k >= 4'd3) ? 2'd1 : 2'd0);
        k_col     = 2'(r_k - 4'd3 * {2'd0, k_row});
        kc        = coef(r_krow[k_row], k_col);
        prod      = $signed({1'b0, r_win[r_k]}) * kc;
        ival      = (quot > 20'sd255) ? 20'sd255 : quot;
    end

    assign wr_en = (r_state == S_READ) && ({22'd0, r_col} < LDEPTH);

    wcn_line_mem #(.DEPTH(LDEPTH), .AW(AW)) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (in_hs),
        .i_rd_addr (r_col[AW-1:0]),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_col[AW-1:0]),
        .i_wr_data ({rd_data[7:0], r_pix})
    );

    wcn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_acc),
        .i_divisor  (r_ksum),
        .o_done     (div_done),
        .o_quotient (quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (in_hs) n_state = S_READ;
            S_READ: begin
                if (interior)    n_state = S_MAC;
                else if (border) n_state = S_OUT_B;
                else             n_state = S_IDLE;
            end
            S_MAC:    if (r_k == 4'd8) n_state = S_DSTART;
            S_DSTART: n_state = S_DIV;
            S_DIV:    if (div_done) n_state = S_OUT_I;
            S_OUT_I:  if (out_hs) n_state = r_bord ? S_OUT_B : S_IDLE;
            S_OUT_B:  if (out_hs) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        div_start     = (r_state == S_DSTART);
        m_axis_tvalid = 1'b0;
        m_axis_tdata  = '0;
        m_axis_tlast  = 1'b0;
        m_axis_tuser  = 1'b0;
        case (r_state)
            S_OUT_I: begin
                m_axis_tvalid = 1'b1;
                m_axis_tdata  = {6'd0, r_icol, r_irow, ival};
                m_axis_tlast  = ~r_bord;
            end
            S_OUT_B: begin
                m_axis_tvalid = 1'b1;
                m_axis_tdata  = {6'd0, r_bcol, r_brow, 12'd0, r_pix};
                m_axis_tlast  = 1'b1;
                m_axis_tuser  = r_fend;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_width  <= 11'd1024;
            r_height <= 12'd1024;
            r_krow[0] <= 24'd0;
            r_krow[1] <= 24'd256;
            r_krow[2] <= 24'd0;
            r_row    <= '0;
            r_col    <= '0;
            for (int i = 0; i < 9; i++) r_win[i] <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WIDTH:  r_width   <= i_cfg_data[10:0];
                    CFG_HEIGHT: r_height  <= i_cfg_data[11:0];
                    CFG_KTOP:   r_krow[0] <= i_cfg_data;
                    CFG_KMID:   r_krow[1] <= i_cfg_data;
                    CFG_KBOT:   r_krow[2] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_READ) begin
                r_row <= n_row;
                r_col <= n_col;
                for (int i = 0; i < 3; i++) begin
                    r_win[i*3]   <= r_win[i*3+1];
                    r_win[i*3+1] <= r_win[i*3+2];
                end
                r_win[2] <= rd_data[15:8];
                r_win[5] <= rd_data[7:0];
                r_win[8] <= r_pix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_hs) begin
            r_pix <= s_axis_tdata;
        end
        if (r_state == S_READ) begin
            r_irow <= r_row - 12'd1;
            r_icol <= r_col - 10'd1;
            r_brow <= r_row;
            r_bcol <= r_col;
            r_bord <= border;
            r_fend <= frame_end;
            r_k    <= 4'd0;
            r_acc  <= '0;
            r_ksum <= '0;
        end else if (r_state == S_MAC) begin
            r_k    <= r_k + 4'd1;
            r_acc  <= r_acc + 20'(prod);
            r_ksum <= r_ksum + 12'(kc);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/wcn_checker.sv =====
// Port-level checker for the 3x3 normalized convolution, bound to the top level.
// Uses the assertion macros header.
`default_nettype none
`include "window_convolution_3x3_normalized_macros.svh"
module wcn_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata,
    input wire logic        m_axis_tlast,
    input wire logic        m_axis_tuser
);
    `WCN_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    `WCN_ASSERT(a_data_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    `WCN_ASSERT_ALWAYS(a_frame_is_last, i_clk, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    `WCN_ASSERT_ALWAYS(a_one_side, i_clk, s_axis_tready |-> !m_axis_tvalid)
    `WCN_ASSERT(a_accept_quiet, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid && !s_axis_tready)
endmodule

bind window_convolution_3x3_normalized wcn_checker u_wcn_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ===== bench/tb_top.sv =====
// Testbench for window_convolution_3x3_normalized: directed table, then random frames.
// Results are checked against table entries or an in-bench 3x3 normalized convolution predictor.
// Depends on wcn_pkg and the RTL top level.
`timescale 1ns / 100ps

module tb_top;
    import wcn_pkg::*;

    localparam int LIMIT      = 3_000_000;
    localparam int SETTLE     = 40;
    localparam int RAND_ITEMS = 260;

    typedef struct packed {
        logic [19:0] value;
        logic [11:0] row;
        logic [9:0]  col;
        logic        run_end;
        logic        frame_end;
    } t_pix_result;

    typedef enum logic {ROW_PIX, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [2:0]  idx;
        logic [23:0] data;
        logic [7:0]  pixel;
        bit          typed;
        t_pix_result result;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [23:0] i_cfg_data = '0;

    window_convolution_3x3_normalized u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    bit [7:0]    older_ln [1024];
    bit [7:0]    newer_ln [1024];
    bit [7:0]    win [3][3];
    int unsigned row_cnt = 0;
    int unsigned col_cnt = 0;
    logic [10:0] img_w = 11'd1024;
    logic [11:0] img_h = 12'd1024;
    logic [23:0] krow [3] = '{24'h0, 24'h000100, 24'h0};

    t_pix_result expected_px_q [$];
    t_pix_result step_px_q [$];

    bit          in_fire = 1'b0;
    bit          cur_typed = 1'b0;
    t_pix_result cur_result;
    int          mismatches = 0;
    int          cycle_cnt = 0;
    int          burst_left = 0;
    int          stall_mode = 0;
    int          stall_cnt = 0;

    function void convolve_step(input logic [7:0] p);
        int unsigned w, h, r, c;
        bit          row_end, frame_end, border;
        logic [7:0]  top, mid;
        int          acc, div, q, k;
        t_pix_result o;
        step_px_q.delete();
        w = (img_w > 1024) ? 1024 : img_w;
        h = img_h;
        r = row_cnt;
        c = col_cnt;
        row_end   = (c + 1 >= w);
        frame_end = row_end && (r + 1 >= h);
        border    = (r == 0) || (c == 0) || row_end || (r + 1 >= h);
        top = 8'd0;
        mid = 8'd0;
        if (c < 1024) begin
            top = older_ln[c];
            mid = newer_ln[c];
            older_ln[c] = mid;
            newer_ln[c] = p;
        end
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = p;
        if (r >= 2 && c >= 2) begin
            acc = 0;
            div = 0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    k = $signed(krow[i][8*j +: 8]);
                    acc += $signed({24'd0, win[i][j]}) * k;
                    div += k;
                end
            end
            if (div == 0) div = 1;
            q = acc / div;
            if (q > 255) q = 255;
            o.value = q[19:0];
            o.row = 12'(r - 1);
            o.col = 10'(c - 1);
            o.run_end = 1'b0;
            o.frame_end = 1'b0;
            step_px_q.push_back(o);
        end
        if (border) begin
            o.value = {12'd0, p};
            o.row = 12'(r);
            o.col = 10'(c);
            o.run_end = 1'b0;
            o.frame_end = frame_end;
            step_px_q.push_back(o);
        end
        if (step_px_q.size() > 0) step_px_q[step_px_q.size() - 1].run_end = 1'b1;
        if (row_end) begin
            col_cnt = 0;
            row_cnt = frame_end ? 0 : ((r + 1) & 12'hFFF);
        end else begin
            col_cnt = (c + 1) & 10'h3FF;
        end
    endfunction

    always @(posedge i_clk) begin
        t_pix_result got, exp_px;
        in_fire = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WIDTH:  img_w = i_cfg_data[10:0];
                    CFG_HEIGHT: img_h = i_cfg_data[11:0];
                    CFG_KTOP:   krow[0] = i_cfg_data;
                    CFG_KMID:   krow[1] = i_cfg_data;
                    CFG_KBOT:   krow[2] = i_cfg_data;
                    default: ;
                endcase
            end
            if (in_fire) begin
                convolve_step(s_axis_tdata);
                if (cur_typed) expected_px_q.push_back(cur_result);
                else foreach (step_px_q[i]) expected_px_q.push_back(step_px_q[i]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[19:0], m_axis_tdata[31:20], m_axis_tdata[41:32],
                       m_axis_tlast, m_axis_tuser};
                if (expected_px_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: val=%h row=%0d col=%0d last=%b lof=%b",
                                 got.value, got.row, got.col, got.run_end, got.frame_end);
                end else begin
                    exp_px = expected_px_q.pop_front();
                    if (got !== exp_px) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp val=%h row=%0d col=%0d last=%b lof=%b",
                                      " | got val=%h row=%0d col=%0d last=%b lof=%b"},
                                     exp_px.value, exp_px.row, exp_px.col, exp_px.run_end,
                                     exp_px.frame_end, got.value, got.row, got.col,
                                     got.run_end, got.frame_end);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == LIMIT) begin
            $display("window_convolution_3x3_normalized verification failed");
            $finish;
        end
    end

    // receiver: switches between no stalls, heavy stalls and light stalls
    always @(negedge i_clk) begin
        if (stall_cnt == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_cnt = $urandom_range(20, 200);
        end
        stall_cnt--;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic send_pixel(input logic [7:0] p, input bit typed, input t_pix_result res);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= p;
        cur_typed = typed;
        cur_result = res;
        do @(negedge i_clk); while (!in_fire);
        burst_left--;
    endtask

    task automatic wait_idle();
        if (s_axis_tvalid) begin
            s_axis_tvalid <= 1'b0;
            burst_left = 0;
        end
        while (expected_px_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
    endtask

    function automatic logic [71:0] make_kernel();
        int          k[9];
        int          mode, sum;
        logic [71:0] packed_k;
        mode = $urandom_range(0, 3);
        sum = 0;
        for (int i = 0; i < 8; i++) begin
            case (mode)
                0:       k[i] = $urandom_range(0, 255) - 128;
                1:       k[i] = $urandom_range(0, 4);
                2:       k[i] = $urandom_range(0, 16) - 8;
                default: k[i] = $urandom_range(0, 28) - 14;
            endcase
            sum += k[i];
        end
        case (mode)
            0, 1:    k[8] = (mode == 0) ? $urandom_range(0, 255) - 128 : $urandom_range(0, 4);
            2:       k[8] = -sum;
            default: k[8] = 1 - sum;
        endcase
        for (int i = 0; i < 9; i++) packed_k[8*i +: 8] = k[i][7:0];
        return packed_k;
    endfunction

    task automatic run_frames(input logic [10:0] w, input logic [11:0] h,
                              input logic [71:0] kern, input int frames, output int sent);
        int          weff, heff;
        logic [7:0]  p;
        t_pix_result none;
        none = '0;
        wait_idle();
        write_reg(CFG_WIDTH, {13'd0, w});
        write_reg(CFG_HEIGHT, {12'd0, h});
        write_reg(CFG_KTOP, kern[23:0]);
        write_reg(CFG_KMID, kern[47:24]);
        write_reg(CFG_KBOT, kern[71:48]);
        i_cfg_we <= 1'b0;
        weff = (w > 1024) ? 1024 : ((w < 1) ? 1 : w);
        heff = (h < 1) ? 1 : h;
        sent = 0;
        repeat (frames * weff * heff) begin
            if ($urandom_range(0, 9) == 0) p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else p = 8'($urandom_range(0, 255));
            send_pixel(p, 1'b0, none);
            sent++;
        end
    endtask

    t_stim_row directed [] = '{
        '{ROW_PIX, CFG_WIDTH, 24'h0, 8'd0,   1'b1, '{20'd0,   12'd0, 10'd0, 1'b1, 1'b0}},
        '{ROW_PIX, CFG_WIDTH, 24'h0, 8'd255, 1'b1, '{20'd255, 12'd0, 10'd1, 1'b1, 1'b0}},
        '{ROW_PIX, CFG_WIDTH, 24'h0, 8'd128, 1'b1, '{20'd128, 12'd0, 10'd2, 1'b1, 1'b0}},
        '{ROW_CFG, CFG_WIDTH,  24'd0, 8'd0, 1'b0, '0},
        '{ROW_CFG, CFG_HEIGHT, 24'd1, 8'd0, 1'b0, '0},
        '{ROW_PIX, CFG_WIDTH, 24'h0, 8'd7,   1'b1, '{20'd7,   12'd0, 10'd3, 1'b1, 1'b1}},
        '{ROW_PIX, CFG_WIDTH, 24'h0, 8'd200, 1'b1, '{20'd200, 12'd0, 10'd0, 1'b1, 1'b1}},
        '{ROW_CFG, CFG_WIDTH,  24'd3, 8'd0, 1'b0, '0},
        '{ROW_CFG, CFG_HEIGHT, 24'd3, 8'd0, 1'b0, '0},
        '{ROW_CFG, CFG_KTOP, 24'h010101, 8'd0, 1'b0, '0},
        '{ROW_CFG, CFG_KMID, 24'h010101, 8'd0, 1'b0, '0},
        '{ROW_CFG, CFG_KBOT, 24'h010101, 8'd0, 1'b0, '0},
        '{ROW_PIX, CFG_WIDTH, 24'h0, 8'd255, 1'b0, '0},
        '{ROW_PIX, CFG_WIDTH, 24'h0, 8'd0,   1'b0, '0},
        '{ROW_PIX, CFG_WIDTH, 24'h0, 8'd255, 1'b0, '0},
        '{ROW_PIX, CFG_WIDTH, 24'h0, 8'd0,   1'b0, '0},
        '{ROW_PIX, CFG_WIDTH, 24'h0, 8'd255, 1'b0, '0},
        '{ROW_PIX, CFG_WIDTH, 24'h0, 8'd0,   1'b0, '0},
        '{ROW_PIX, CFG_WIDTH, 24'h0, 8'd255, 1'b0, '0},
        '{ROW_PIX, CFG_WIDTH, 24'h0, 8'd0,   1'b0, '0},
        '{ROW_PIX, CFG_WIDTH, 24'h0, 8'd255, 1'b0, '0},
        // zero-sum kernel with a negative quotient
        '{ROW_CFG, CFG_KTOP, 24'h000000, 8'd0, 1'b0, '0},
        '{ROW_CFG, CFG_KMID, 24'h0001FF, 8'd0, 1'b0, '0},
        '{ROW_CFG, CFG_KBOT, 24'h000000, 8'd0, 1'b0, '0},
        '{ROW_PIX, CFG_WIDTH, 24'h0, 8'd0,   1'b0, '0},
        '{ROW_PIX, CFG_WIDTH, 24'h0, 8'd255, 1'b0, '0},
        '{ROW_PIX, CFG_WIDTH, 24'h0, 8'd0,   1'b0, '0},
        '{ROW_PIX, CFG_WIDTH, 24'h0, 8'd255, 1'b0, '0},
        '{ROW_PIX, CFG_WIDTH, 24'h0, 8'd0,   1'b0, '0},
        '{ROW_PIX, CFG_WIDTH, 24'h0, 8'd0,   1'b0, '0},
        '{ROW_PIX, CFG_WIDTH, 24'h0, 8'd1,   1'b0, '0},
        '{ROW_PIX, CFG_WIDTH, 24'h0, 8'd2,   1'b0, '0},
        '{ROW_PIX, CFG_WIDTH, 24'h0, 8'd3,   1'b0, '0}
    };

    initial begin
        int          rand_sent, sent;
        logic [10:0] w;
        logic [11:0] h;
        bit          prev_cfg;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        prev_cfg = 1'b0;
        foreach (directed[i]) begin
            if (directed[i].kind == ROW_CFG) begin
                if (!prev_cfg) wait_idle();
                write_reg(directed[i].idx, directed[i].data);
                prev_cfg = 1'b1;
            end else begin
                if (prev_cfg) i_cfg_we <= 1'b0;
                prev_cfg = 1'b0;
                send_pixel(directed[i].pixel, directed[i].typed, directed[i].result);
            end
        end

        rand_sent = 0;
        while (rand_sent < RAND_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       w = 11'($urandom_range(0, 2));
                1:       w = 11'd3;
                default: w = 11'($urandom_range(3, 14));
            endcase
            case ($urandom_range(0, 9))
                0:       h = 12'($urandom_range(0, 2));
                1:       h = 12'd3;
                default: h = 12'($urandom_range(3, 7));
            endcase
            run_frames(w, h, make_kernel(), $urandom_range(1, 2), sent);
            rand_sent += sent;
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("window_convolution_3x3_normalized verification clean");
        end else begin
            $display("window_convolution_3x3_normalized verification failed");
        end
        $finish;
    end
endmodule

// ===== window_convolution_3x3_normalized.f =====
+incdir+rtl/core
rtl/core/wcn_pkg.sv
rtl/core/wcn_line_mem.sv
rtl/core/wcn_div.sv
rtl/core/window_convolution_3x3_normalized.sv
rtl/core/wcn_checker.sv
bench/tb_top.sv
